// ===== design/e2q_pkg.sv =====
// Shared constants and helpers for the Euler-angle to quaternion core.
package e2q_pkg;

  localparam int unsigned ANGLE_W      = 16;
  localparam int unsigned QUAT_W       = 16;
  localparam int unsigned CORDIC_W     = 34;   // Q2.30 plus guard bits
  localparam int unsigned ATAN_LEN     = 24;
  localparam int unsigned STAGES_DEF   = 16;
  localparam int unsigned SC_W         = 18;   // sin/cos in Q.16
  localparam int unsigned PROD2_W      = 2 * SC_W;
  localparam int unsigned PROD3_W      = 3 * SC_W;
  localparam int unsigned RAD_W        = 19;   // width of the radian scale factor

  localparam logic signed [ANGLE_W:0]    HALF_TURN    = 17'sd23040;
  localparam logic signed [ANGLE_W:0]    QUARTER_TURN = 17'sd11520;
  localparam logic signed [RAD_W-1:0]    ANG_SCALE    = 19'sd146409;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN  = 34'sd652032874;

  typedef logic signed [CORDIC_W-1:0] cordic_t;
  typedef logic signed [SC_W-1:0] sc_t;

  typedef struct packed {
    cordic_t cx;
    cordic_t cy;
    cordic_t cz;
    logic    flip;
  } rot_t;

  function automatic cordic_t atan_lut(input int unsigned idx);
    cordic_t r;
    unique case (idx)
      0: r = 34'sd843314856;   1: r = 34'sd497837829;
      2: r = 34'sd263043836;   3: r = 34'sd133525158;
      4: r = 34'sd67021686;    5: r = 34'sd33543515;
      6: r = 34'sd16775850;    7: r = 34'sd8388437;
      8: r = 34'sd4194282;     9: r = 34'sd2097149;
      10: r = 34'sd1048575;    11: r = 34'sd524287;
      12: r = 34'sd262143;     13: r = 34'sd131071;
      14: r = 34'sd65535;      15: r = 34'sd32767;
      16: r = 34'sd16383;      17: r = 34'sd8191;
      18: r = 34'sd4095;       19: r = 34'sd2047;
      20: r = 34'sd1023;       21: r = 34'sd511;
      22: r = 34'sd255;        23: r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/euler_to_quaternion_core.sv =====
// Euler angles (YXZ order) to unit quaternion, pipelined CORDIC datapath.
//
// One item per cycle while the output is not stalled, fully pipelined. N is
// CORDIC_STAGES capped at 24. Stages: one for fold and radian scaling, one per
// CORDIC iteration (all three angles in parallel), one for sin/cos rounding,
// two for the triple products, one for sum, rounding and saturation. tready on
// the input follows the output side: the whole pipe advances whenever the
// output register is empty or being taken, and freezes otherwise.
// s_tdata: angle_x[15:0], angle_y[31:16], angle_z[47:32].
// m_tdata: quat_x, quat_y, quat_z, quat_w in 16-bit fields from the bottom.
module euler_to_quaternion_core #(
  parameter int unsigned CORDIC_STAGES = e2q_pkg::STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // angle_x, angle_y, angle_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // quat_x, quat_y, quat_z, quat_w
);

  localparam int unsigned NSTG =
    (CORDIC_STAGES > e2q_pkg::ATAN_LEN) ? e2q_pkg::ATAN_LEN : CORDIC_STAGES;
  localparam int unsigned DEPTH = NSTG + 5;

  logic adv;
  logic [DEPTH-1:0] vld;

  assign adv      = !vld[DEPTH-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], s_tvalid};
    end
  end

  // Stage 0: fold and scale to radians
  e2q_pkg::rot_t rot [3][NSTG+1];

  for (genvar a = 0; a < 3; a++) begin : g_ang
    logic signed [e2q_pkg::ANGLE_W:0] h, hf;
    logic signed [e2q_pkg::ANGLE_W+e2q_pkg::RAD_W:0] hr;
    logic fl;
    always_comb begin
      h = {s_tdata[a*16+15], s_tdata[a*16 +: 16]};
      hf = h;
      fl = 1'b0;
      if (h > e2q_pkg::QUARTER_TURN) begin
        hf = h - e2q_pkg::HALF_TURN;
        fl = 1'b1;
      end else if (h < -e2q_pkg::QUARTER_TURN) begin
        hf = h + e2q_pkg::HALF_TURN;
        fl = 1'b1;
      end
      hr = hf * e2q_pkg::ANG_SCALE;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rot[a][0].cx   <= e2q_pkg::CORDIC_GAIN;
        rot[a][0].cy   <= '0;
        rot[a][0].cz   <= e2q_pkg::CORDIC_W'(hr);
        rot[a][0].flip <= fl;
      end
    end

    for (genvar i = 0; i < NSTG; i++) begin : g_it
      always_ff @(posedge clk) begin
        if (adv) begin
          rot[a][i+1].flip <= rot[a][i].flip;
          if (!rot[a][i].cz[e2q_pkg::CORDIC_W-1]) begin
            rot[a][i+1].cx <= rot[a][i].cx - (rot[a][i].cy >>> i);
            rot[a][i+1].cy <= rot[a][i].cy + (rot[a][i].cx >>> i);
            rot[a][i+1].cz <= rot[a][i].cz - e2q_pkg::atan_lut(i);
          end else begin
            rot[a][i+1].cx <= rot[a][i].cx + (rot[a][i].cy >>> i);
            rot[a][i+1].cy <= rot[a][i].cy - (rot[a][i].cx >>> i);
            rot[a][i+1].cz <= rot[a][i].cz + e2q_pkg::atan_lut(i);
          end
        end
      end
    end
  end

  // Round to Q.16 and apply flip
  e2q_pkg::sc_t sn [3];
  e2q_pkg::sc_t cs [3];
  for (genvar a = 0; a < 3; a++) begin : g_rnd
    e2q_pkg::cordic_t rc, rs;
    e2q_pkg::sc_t c16, s16;
    always_comb begin
      rc  = (rot[a][NSTG].cx + e2q_pkg::CORDIC_W'(8192)) >>> 14;
      rs  = (rot[a][NSTG].cy + e2q_pkg::CORDIC_W'(8192)) >>> 14;
      c16 = e2q_pkg::SC_W'(rc);
      s16 = e2q_pkg::SC_W'(rs);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        cs[a] <= rot[a][NSTG].flip ? -c16 : c16;
        sn[a] <= rot[a][NSTG].flip ? -s16 : s16;
      end
    end
  end

  // Pair products: cy*cz, sy*sz, sy*cz, cy*sz with sx/cx held alongside
  logic signed [e2q_pkg::PROD2_W-1:0] p_cycz, p_sysz, p_sycz, p_cysz;
  e2q_pkg::sc_t sx_d, cx_d;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_cycz <= cs[1] * cs[2];
      p_sysz <= sn[1] * sn[2];
      p_sycz <= sn[1] * cs[2];
      p_cysz <= cs[1] * sn[2];
      sx_d   <= sn[0];
      cx_d   <= cs[0];
    end
  end

  logic signed [e2q_pkg::PROD3_W-1:0] t [8];
  always_ff @(posedge clk) begin
    if (adv) begin
      t[0] <= sx_d * p_cycz;  t[1] <= cx_d * p_sysz;
      t[2] <= cx_d * p_sycz;  t[3] <= sx_d * p_cysz;
      t[4] <= cx_d * p_cysz;  t[5] <= sx_d * p_sycz;
      t[6] <= cx_d * p_cycz;  t[7] <= sx_d * p_sysz;
    end
  end

  function automatic logic [15:0] to_q15(input logic signed [e2q_pkg::PROD3_W:0] v);
    logic signed [e2q_pkg::PROD3_W:0] r;
    r = (v + $signed((e2q_pkg::PROD3_W+1)'(64'h1_0000_0000))) >>> 33;
    if (r > 32767) return 16'h7FFF;
    if (r < -32768) return 16'h8000;
    return r[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata[15:0]  <= to_q15({t[0][53], t[0]} + {t[1][53], t[1]});
      m_tdata[31:16] <= to_q15({t[2][53], t[2]} - {t[3][53], t[3]});
      m_tdata[47:32] <= to_q15({t[4][53], t[4]} - {t[5][53], t[5]});
      m_tdata[63:48] <= to_q15({t[6][53], t[6]} + {t[7][53], t[7]});
    end
  end

`ifndef ASSERT_OFF
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $stable(vld))
    else $error("pipeline moved during stall");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for the Euler-angle to quaternion core.
module testbench;

  localparam int unsigned STAGES    = e2q_pkg::STAGES_DEF;
  localparam int unsigned LATENCY   = STAGES + 5;
  localparam int unsigned N_RANDOM  = 1400;
  localparam int unsigned CYCLE_MAX = 400000;
  localparam longint      Q30_GAIN  = 652032874;
  localparam longint      HALF_Q7   = 23040;
  localparam longint      QUART_Q7  = 11520;
  localparam longint      RAD_SCALE = 146409;

  typedef struct packed {
    logic signed [15:0] ang_z;
    logic signed [15:0] ang_y;
    logic signed [15:0] ang_x;
  } angles_t;

  typedef struct packed {
    logic signed [15:0] qw;
    logic signed [15:0] qz;
    logic signed [15:0] qy;
    logic signed [15:0] qx;
  } quat_t;

  typedef struct {
    angles_t ang;
    logic    known;
    quat_t   q;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;

  quat_t  quat_queue[$];
  int     errors = 0;
  int     accepted = 0;
  int     received = 0;
  int     cycles = 0;
  bit     calm = 1'b0;
  row_t   rows[$];

  euler_to_quaternion_core #(.CORDIC_STAGES(STAGES)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // floor shift for signed values
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  // half angle (deg Q.7) to sin/cos in Q.16
  function automatic void half_sin_cos(longint h, output longint s16, output longint c16);
    longint px, py, pz, nx;
    bit     flip;
    longint atan_tab[24];
    atan_tab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
                 262143, 131071, 65535, 32767, 16383, 8191,
                 4095, 2047, 1023, 511, 255, 127};
    flip = 1'b0;
    if (h > QUART_Q7) begin
      h -= HALF_Q7;
      flip = 1'b1;
    end else if (h < -QUART_Q7) begin
      h += HALF_Q7;
      flip = 1'b1;
    end
    px = Q30_GAIN;
    py = 0;
    pz = h * RAD_SCALE;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      if (pz >= 0) begin
        nx = px - floor_shr(py, i);
        py = py + floor_shr(px, i);
        pz -= atan_tab[i];
      end else begin
        nx = px + floor_shr(py, i);
        py = py - floor_shr(px, i);
        pz += atan_tab[i];
      end
      px = nx;
    end
    c16 = floor_shr(px + 8192, 14);
    s16 = floor_shr(py + 8192, 14);
    if (flip) begin
      c16 = -c16;
      s16 = -s16;
    end
  endfunction

  function automatic logic signed [15:0] round_sat_q15(longint q48);
    longint v;
    v = floor_shr(q48 + (longint'(1) << 32), 33);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic quat_t yxz_quaternion(angles_t a);
    longint sx, cx, sy, cy, sz, cz;
    quat_t  q;
    half_sin_cos(longint'(a.ang_x), sx, cx);
    half_sin_cos(longint'(a.ang_y), sy, cy);
    half_sin_cos(longint'(a.ang_z), sz, cz);
    q.qx = round_sat_q15(sx * cy * cz + cx * sy * sz);
    q.qy = round_sat_q15(cx * sy * cz - sx * cy * sz);
    q.qz = round_sat_q15(cx * cy * sz - sx * sy * cz);
    q.qw = round_sat_q15(cx * cy * cz + sx * sy * sz);
    return q;
  endfunction

  task automatic report(string what, quat_t got, quat_t want);
    errors++;
    $display("mismatch %s at result %0d: got %h want %h", what, received, got, want);
  endtask

  // output side: random stalls, check in order
  initial begin
    int stall;
    quat_t got, want;
    @(negedge clk);
    forever begin
      stall = calm ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = m_tdata;
      if (quat_queue.size() == 0) begin
        report("unexpected item", got, '0);
      end else begin
        want = quat_queue.pop_front();
        if (got.qx !== want.qx) report("quat_x", got, want);
        if (got.qy !== want.qy) report("quat_y", got, want);
        if (got.qz !== want.qz) report("quat_z", got, want);
        if (got.qw !== want.qw) report("quat_w", got, want);
      end
      received++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic send(angles_t a, bit gaps);
    int gap;
    gap = (gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= a;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    quat_queue.push_back(yxz_quaternion(a));
    accepted++;
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'(11520 + $urandom_range(0, 2) - 1);   // near 90 deg half
      1: return -16'(11520 + $urandom_range(0, 2) - 1);
      2: return 16'($urandom_range(0, 1) ? 16'h7FFF - $urandom_range(0, 3)
                                          : 16'h8000 + $urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic row_t mk(int ax, int ay, int az, bit known, quat_t q);
    row_t r;
    r.ang = {16'(az), 16'(ay), 16'(ax)};
    r.known = known;
    r.q = q;
    return r;
  endfunction

  initial begin
    angles_t a;
    quat_t   q;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    // zero angles: w is +1 and saturates; CORDIC residue leaves sine at -1 LSB,
    // which pulls y and z down to -1
    rows.push_back(mk(0, 0, 0, 1'b1, {16'sd32767, -16'sd1, -16'sd1, 16'sd0}));
    rows.push_back(mk(32767, 32767, 32767, 0, '0));
    rows.push_back(mk(-32768, -32768, -32768, 0, '0));
    rows.push_back(mk(11520, 0, 0, 0, '0));       // exactly 90 deg half: no fold
    rows.push_back(mk(0, -11520, 0, 0, '0));
    rows.push_back(mk(0, 0, 11521, 0, '0));       // just past: fold
    rows.push_back(mk(-11521, 11521, -11521, 0, '0));
    rows.push_back(mk(23040, 23040, 23040, 0, '0));
    rows.push_back(mk(-11520, 5760, 0, 0, '0));
    rows.push_back(mk(1, -1, 1, 0, '0));
    rows.push_back(mk(16'h5555, 16'hAAAA, 16'h0F0F, 0, '0));
    rows.push_back(mk(16'hAAAA, 16'h5555, 16'hF0F0, 0, '0));
    foreach (rows[i]) begin
      send(rows[i].ang, 1'b0);
      if (rows[i].known) begin
        q = quat_queue[$];
        if (q !== rows[i].q) report("directed table", q, rows[i].q);
      end
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        // let the pipe drain completely before resuming
        s_tvalid <= 1'b0;
        while (quat_queue.size() != 0) @(negedge clk);
      end
      if (n == N_RANDOM - 200) calm = 1'b1;
      a.ang_x = rand_angle();
      a.ang_y = rand_angle();
      a.ang_z = rand_angle();
      send(a, !calm);
    end
    s_tvalid <= 1'b0;
    while (quat_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    $display("sent %0d angle triples, checked %0d quaternions", accepted, received);
    $display("covered fold boundaries, field extremes, stalls and back-to-back traffic");
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
